// File: hw/rtl/dsm_pkg.sv
package dsm_pkg;

   // Table geometry: one bank per automaton state, one word per symbol.
   localparam int NUM_STATES  = 64;
   localparam int NUM_SYMBOLS = 256;
   localparam int STATE_W     = 6;
   localparam int SYMBOL_W    = 8;
   localparam int MODE_W      = 2;
   localparam int SYM_AW      = $clog2(NUM_SYMBOLS);

   // Item modes.
   localparam logic [MODE_W-1:0] MODE_WR_TRANS  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_WR_ACCEPT = 2'd1;
   localparam logic [MODE_W-1:0] MODE_STEP      = 2'd2;
   localparam logic [MODE_W-1:0] MODE_EMPTY     = 2'd3;

   // One transition table word.
   typedef struct packed {
      logic               valid;
      logic [STATE_W-1:0] next;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // All transitions of one symbol, one word per source state.
   typedef entry_type [NUM_STATES-1:0] row_type;

   // Transition write request from the control path to the table.
   typedef struct packed {
      logic                en;
      logic [STATE_W-1:0]  state;
      logic [SYMBOL_W-1:0] symbol;
      entry_type           entry;
   } tbl_wr_type;

endpackage

// File: hw/rtl/dsm_if.sv
// Input item channel.
interface dsm_req_if;
   logic                         valid;
   logic                         ready;
   logic [dsm_pkg::MODE_W-1:0]   mode;
   logic [dsm_pkg::STATE_W-1:0]  from_state;
   logic [dsm_pkg::SYMBOL_W-1:0] symbol;
   logic [dsm_pkg::STATE_W-1:0]  to_state;
   logic                         entry_valid;
   logic                         first_symbol;
   logic                         last_symbol;

   modport source (
      output valid, mode, from_state, symbol, to_state, entry_valid, first_symbol,
             last_symbol,
      input  ready
   );
   modport sink (
      input  valid, mode, from_state, symbol, to_state, entry_valid, first_symbol,
             last_symbol,
      output ready
   );
endinterface

// Result item channel.
interface dsm_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        string_done;
   logic                        accepted;
   logic [dsm_pkg::STATE_W-1:0] current_state;
   logic                        dead;

   modport source (
      output valid, string_done, accepted, current_state, dead,
      input  ready
   );
   modport sink (
      input  valid, string_done, accepted, current_state, dead,
      output ready
   );
endinterface

// File: hw/rtl/dsm_ram.sv
module dsm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Single write port, registered read that holds when not enabled.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/dsm_next_table.sv
module dsm_next_table (
   input  logic                       clock,
   input  logic                       reset,
   input  dsm_pkg::tbl_wr_type        wr,
   input  logic                       rd_en,
   input  logic [dsm_pkg::SYM_AW-1:0] rd_addr,
   output dsm_pkg::row_type           rows,
   output logic                       busy,
   output logic [dsm_pkg::SYM_AW-1:0] clr_addr
);

   logic                       clr_ff;
   logic                       clr_in;
   logic [dsm_pkg::SYM_AW-1:0] clr_addr_ff;
   logic [dsm_pkg::SYM_AW-1:0] clr_addr_in;
   logic [dsm_pkg::SYM_AW-1:0] wr_addr;
   dsm_pkg::entry_type         wr_data;

   // Clearing sweep after reset: one symbol row of every bank per cycle.
   always_comb begin
      clr_in      = clr_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == dsm_pkg::SYM_AW'(dsm_pkg::NUM_SYMBOLS - 1)) begin
            clr_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_ff      <= clr_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   assign busy     = clr_ff;
   assign clr_addr = clr_addr_ff;
   assign wr_addr  = clr_ff ? clr_addr_ff : wr.symbol[dsm_pkg::SYM_AW-1:0];
   assign wr_data  = clr_ff ? '0 : wr.entry;

   // One bank per source state; all banks are read at the same symbol.
   for (genvar b = 0; b < dsm_pkg::NUM_STATES; b++) begin : g_bank
      logic bank_we;

      assign bank_we = clr_ff || (wr.en && (wr.state == dsm_pkg::STATE_W'(b)));

      dsm_ram #(
         .WIDTH(dsm_pkg::ENTRY_W),
         .DEPTH(dsm_pkg::NUM_SYMBOLS)
      ) u_bank (
         .clock   (clock),
         .wr_en   (bank_we),
         .wr_addr (wr_addr),
         .wr_data (wr_data),
         .rd_en   (rd_en),
         .rd_addr (rd_addr),
         .rd_data (rows[b])
      );
   end

endmodule

// File: hw/rtl/dfa_string_matcher_top.sv
// Automaton string recognizer with a loadable transition table.
// Channels: req_chan takes one item per handshake (valid and ready high at a
// rising edge); rsp_chan returns exactly one result item for every input item,
// in order. csr_wr_en with csr_wr_data loads the start state; write it only
// while no item is in flight.
// Items in write-transition mode load the table, write-accept items set a
// state's accepting flag, step items advance the automaton by one symbol and
// empty-string items return the verdict of the start state.
// A result passes the table read into the read stage, then the output
// register together with the accepting flag read. Throughput: one item per
// cycle while rsp_chan.ready is high and the table is not clearing. The table
// is banked by source state and read by symbol, so the next-state select from
// the registered row closes the feedback loop.
// Reset: control state clears, then a sweep over every symbol row zeroes the
// transition table and the accepting flags; req_chan.ready stays low during
// the sweep, while configuration writes are still taken.
// Stall: when rsp_chan.ready is low the result holds in the output register,
// one more item can sit in the read stage, and req_chan.ready then drops.
module dfa_string_matcher_top (
   input  logic                        clock,
   input  logic                        reset,
   dsm_req_if.sink                     req_chan,
   dsm_rsp_if.source                   rsp_chan,
   input  logic                        csr_wr_en,
   input  logic [dsm_pkg::STATE_W-1:0] csr_wr_data
);

   // Configuration and automaton state.
   logic [dsm_pkg::STATE_W-1:0]    start_ff;
   logic [dsm_pkg::STATE_W-1:0]    present_ff;
   logic [dsm_pkg::STATE_W-1:0]    present_in;
   logic                           dead_ff;
   logic                           dead_in;

   // Accepting flag memory.
   logic                        acc_we;
   logic [dsm_pkg::STATE_W-1:0] acc_wr_addr;
   logic                        acc_wr_data;
   logic                        acc_flag;
   logic [dsm_pkg::SYM_AW-1:0]  clr_addr;

   // Read stage.
   logic                        s1_valid_ff;
   logic [dsm_pkg::MODE_W-1:0]  s1_mode_ff;
   logic [dsm_pkg::STATE_W-1:0] s1_from_ff;
   logic                        s1_entry_valid_ff;
   logic                        s1_first_ff;
   logic                        s1_last_ff;

   // Output register.
   logic                        out_valid_ff;
   logic                        out_valid_in;
   logic                        out_done_ff;
   logic                        out_done_in;
   logic                        out_acc_ff;
   logic                        out_acc_in;

   // Handshake and table signals.
   logic                        out_free;
   logic                        s1_commit;
   logic                        s1_free;
   logic                        accept;
   logic                        tbl_busy;
   dsm_pkg::tbl_wr_type         tbl_wr;
   dsm_pkg::row_type            rows;

   // Step computation.
   logic                        reload;
   logic [dsm_pkg::STATE_W-1:0] base_state;
   logic                        base_dead;
   dsm_pkg::entry_type          entry;

   // Pipeline flow control.
   assign out_free  = !out_valid_ff || rsp_chan.ready;
   assign s1_commit = s1_valid_ff && out_free;
   assign s1_free   = !s1_valid_ff || s1_commit;
   assign accept    = req_chan.valid && req_chan.ready;

   assign req_chan.ready = s1_free && !tbl_busy;

   // Transition writes go to the table at acceptance; every item reads its symbol row.
   always_comb begin
      tbl_wr.en     = accept && (req_chan.mode == dsm_pkg::MODE_WR_TRANS);
      tbl_wr.state  = req_chan.from_state;
      tbl_wr.symbol = req_chan.symbol;
      tbl_wr.entry  = '{valid: req_chan.entry_valid, next: req_chan.to_state};
   end

   dsm_next_table u_table (
      .clock    (clock),
      .reset    (reset),
      .wr       (tbl_wr),
      .rd_en    (accept),
      .rd_addr  (req_chan.symbol[dsm_pkg::SYM_AW-1:0]),
      .rows     (rows),
      .busy     (tbl_busy),
      .clr_addr (clr_addr)
   );

   // Read stage registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_free) begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_mode_ff        <= req_chan.mode;
         s1_from_ff        <= req_chan.from_state;
         s1_entry_valid_ff <= req_chan.entry_valid;
         s1_first_ff       <= req_chan.first_symbol;
         s1_last_ff        <= req_chan.last_symbol;
      end
   end

   // Pick the starting point of this item and its transition word.
   assign reload     = (s1_mode_ff == dsm_pkg::MODE_EMPTY) ||
                       ((s1_mode_ff == dsm_pkg::MODE_STEP) && s1_first_ff);
   assign base_state = reload ? start_ff : present_ff;
   assign base_dead  = reload ? 1'b0 : dead_ff;
   assign entry      = rows[base_state];

   // Commit of the item in the read stage. The output keeps whether the
   // verdict needs the accepting flag, which is read at the same edge.
   always_comb begin
      present_in   = present_ff;
      dead_in      = dead_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      out_done_in  = out_done_ff;
      out_acc_in   = out_acc_ff;
      if (s1_commit) begin
         out_valid_in = 1'b1;
         out_done_in  = 1'b0;
         out_acc_in   = 1'b0;
         case (s1_mode_ff)
            dsm_pkg::MODE_WR_TRANS: begin
            end
            dsm_pkg::MODE_WR_ACCEPT: begin
            end
            dsm_pkg::MODE_STEP: begin
               present_in = base_state;
               dead_in    = base_dead;
               if (!base_dead) begin
                  if (entry.valid) begin
                     present_in = entry.next;
                  end else begin
                     dead_in = 1'b1;
                  end
               end
               out_done_in = s1_last_ff;
               out_acc_in  = s1_last_ff && !dead_in;
            end
            dsm_pkg::MODE_EMPTY: begin
               present_in  = start_ff;
               dead_in     = 1'b0;
               out_done_in = 1'b1;
               out_acc_in  = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // Accepting flags: cleared by the sweep, written by write-accept items and
   // read at the state after each committed item.
   assign acc_we      = tbl_busy || (s1_commit && (s1_mode_ff == dsm_pkg::MODE_WR_ACCEPT));
   assign acc_wr_addr = tbl_busy ? clr_addr[dsm_pkg::STATE_W-1:0] : s1_from_ff;
   assign acc_wr_data = !tbl_busy && s1_entry_valid_ff;

   dsm_ram #(
      .WIDTH(1),
      .DEPTH(dsm_pkg::NUM_STATES)
   ) u_accept (
      .clock   (clock),
      .wr_en   (acc_we),
      .wr_addr (acc_wr_addr),
      .wr_data (acc_wr_data),
      .rd_en   (s1_commit),
      .rd_addr (present_in),
      .rd_data (acc_flag)
   );

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff     <= '0;
         present_ff   <= '0;
         dead_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            start_ff <= csr_wr_data;
         end
         present_ff   <= present_in;
         dead_ff      <= dead_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // The result item carries the state after the item.
   always_ff @(posedge clock) begin
      out_done_ff <= out_done_in;
      out_acc_ff  <= out_acc_in;
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.string_done   = out_done_ff;
   assign rsp_chan.accepted      = out_acc_ff && acc_flag;
   assign rsp_chan.current_state = present_ff;
   assign rsp_chan.dead          = dead_ff;

endmodule

// File: hw/rtl/dsm_checker.sv
module dsm_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_string_done,
   input logic rsp_accepted,
   input logic rsp_dead
);

   // A result item waiting for the receiver is not withdrawn.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item dropped while stalled");

   // Acceptance is only reported with a finished string.
   a_acc_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_accepted |-> rsp_string_done)
      else $error("accepted without string_done");

   // A dead string is never accepted.
   a_acc_alive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_accepted |-> !rsp_dead)
      else $error("dead string reported as accepted");

   // The table clearing sweep keeps the input closed right after reset.
   a_clear_closed: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready)
      else $error("input open during table clearing");

   // No result item appears right after reset.
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result item right after reset");

endmodule

bind dfa_string_matcher_top dsm_checker u_dsm_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_string_done (rsp_chan.string_done),
   .rsp_accepted    (rsp_chan.accepted),
   .rsp_dead        (rsp_chan.dead)
);
